FILE: sv/scf_pkg.sv
// scf_pkg: shared constants and types for the stereo comb filter
// configuration register codes, widths and reset values; no dependencies
package scf_pkg;

    localparam int MAX_DELAY_DEF    = 65536;
    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int LEN_W      = 17;
    localparam int GAIN_W     = 17;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY_LENGTH  = 2'd0,
        CFG_GAIN          = 2'd1,
        CFG_FEEDBACK_MODE = 2'd2
    } t_cfg_idx;

    localparam logic [LEN_W-1:0]  DELAY_LENGTH_RST = 17'd4800;
    localparam logic [GAIN_W-1:0] GAIN_RST         = 17'd32768;
    localparam logic [GAIN_W-1:0] GAIN_UNITY       = 17'd65536;

    // gain is unsigned q1.16: product is rounded by half an lsb then shifted
    localparam int GAIN_FRAC = 16;

endpackage

FILE: sv/scf_ram.sv
// scf_ram: generic single-write, single-read RAM with registered read data
// read during write to the same address returns the old contents; no dependencies
module scf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/scf_lane.sv
// scf_lane: one channel of the comb filter, x + round(s * gain) saturated
// uses scf_pkg for the gain format
module scf_lane #(
    parameter int SAMPLE_WIDTH = scf_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic signed [SAMPLE_WIDTH-1:0] i_x,
    input  logic signed [SAMPLE_WIDTH-1:0] i_s,
    input  logic [scf_pkg::GAIN_W-1:0]     i_gain,
    output logic signed [SAMPLE_WIDTH-1:0] o_y
);
    import scf_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam int PW = SW + GAIN_W + 1;

    logic signed [PW-1:0]        w_s_ext;
    logic signed [PW-1:0]        w_g_ext;
    logic signed [PW-1:0]        w_prod;
    logic signed [PW-1:0]        w_rnd;
    logic signed [PW-GAIN_FRAC-1:0] w_scaled;
    logic signed [SW+2:0]        w_sum;
    logic [3:0]                  w_top;

    assign w_s_ext  = PW'(i_s);
    assign w_g_ext  = $signed(PW'(i_gain));
    assign w_prod   = w_s_ext * w_g_ext;
    // half lsb then floor: halves go towards plus infinity
    assign w_rnd    = w_prod + $signed(PW'(1) <<< (GAIN_FRAC - 1));
    assign w_scaled = $signed(w_rnd[PW-1:GAIN_FRAC]);
    assign w_sum    = (SW+3)'(i_x) + (SW+3)'(w_scaled);
    assign w_top    = w_sum[SW+2:SW-1];

    always_comb begin
        if (w_top == 4'b0000 || w_top == 4'b1111) begin
            o_y = w_sum[SW-1:0];
        end else if (w_sum[SW+2]) begin
            o_y = {1'b1, {(SW-1){1'b0}}};
        end else begin
            o_y = {1'b0, {(SW-1){1'b1}}};
        end
    end

endmodule

FILE: sv/scf_merge.sv
// scf_merge: forms the delay store word (lane inputs or results) and the output register
// uses scf_pkg; holds one result word while the output is stalled
module scf_merge #(
    parameter int SAMPLE_WIDTH = scf_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  logic                            i_feedback,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_left_x,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_right_x,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_left_y,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_right_y,
    output logic [2*SAMPLE_WIDTH-1:0]       o_store_word,
    output logic                            o_free,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]  o_left_out,
    output logic signed [SAMPLE_WIDTH-1:0]  o_right_out
);
    import scf_pkg::*;

    logic                           r_vld;
    logic signed [SAMPLE_WIDTH-1:0] r_left;
    logic signed [SAMPLE_WIDTH-1:0] r_right;

    // feedback keeps the saturated outputs, feedforward the inputs
    assign o_store_word = i_feedback ? {i_left_y, i_right_y} : {i_left_x, i_right_x};
    assign o_free       = !r_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_left  <= i_left_y;
            r_right <= i_right_y;
        end
    end

    assign o_out_valid = r_vld;
    assign o_left_out  = r_left;
    assign o_right_out = r_right;

endmodule

FILE: sv/stereo_comb_filter_core.sv
// stereo_comb_filter_core: stereo comb filter, one shared delay memory and two lanes
// uses scf_pkg, scf_ram, scf_lane and scf_merge
//
//  channel   direction  handshake                       payload
//  in        sink       i_in_valid / o_in_stall         i_left_in, i_right_in
//  out       source     o_out_valid / i_out_stall       o_left_out, o_right_out
//  cfg       sink       i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
// one stereo word per cycle sustained while the output does not stall; an accepted word is
// registered in the read stage and then in the output register of scf_merge, where it is on offer
// that rate is set by the read, multiply-add and write-back loop on the
// delay memory, with the word written at the same edge forwarded to the next read
// synchronous active-low reset; never-written entries read as zero through a fill
// count, so there is no clearing pass and the block is ready right after reset
// under output stall one further word is taken and held before input stalls
module stereo_comb_filter_core #(
    parameter int MAX_DELAY    = scf_pkg::MAX_DELAY_DEF,
    parameter int SAMPLE_WIDTH = scf_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_left_in,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_right_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]    o_left_out,
    output logic signed [SAMPLE_WIDTH-1:0]    o_right_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [scf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [scf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import scf_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam int AW = $clog2(MAX_DELAY);
    localparam int LW = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;
    localparam logic [LW-1:0] MAX_LEN = LW'(MAX_DELAY);

    // configuration
    logic [LEN_W-1:0]  r_delay_length;
    logic [GAIN_W-1:0] r_gain;
    logic              r_feedback;

    // line position and fill count
    logic [AW-1:0]     r_pos;
    logic [AW-1:0]     n_pos;
    logic [AW:0]       r_fill;

    // read stage
    logic              r_a_vld;
    logic [AW-1:0]     r_a_addr;
    logic signed [SW-1:0] r_a_left;
    logic signed [SW-1:0] r_a_right;
    logic              r_a_fwd_vld;
    logic [2*SW-1:0]   r_a_fwd;
    logic              r_a_init;

    logic [LW-1:0]     w_len_raw;
    logic [LW-1:0]     w_len;
    logic [LW-1:0]     w_pos_inc;
    logic [GAIN_W-1:0] w_gain;
    logic              w_accept;
    logic              w_a_move;
    logic              w_free;
    logic [2*SW-1:0]   w_rdata;
    logic [2*SW-1:0]   w_stored;
    logic [2*SW-1:0]   w_store_word;
    logic signed [SW-1:0] w_left_y;
    logic signed [SW-1:0] w_right_y;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_length <= DELAY_LENGTH_RST;
            r_gain         <= GAIN_RST;
            r_feedback     <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DELAY_LENGTH:  r_delay_length <= i_cfg_data[LEN_W-1:0];
                CFG_GAIN:          r_gain         <= i_cfg_data[GAIN_W-1:0];
                CFG_FEEDBACK_MODE: r_feedback     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective length clamped to 1..MAX_DELAY, gain clamped to unity
    assign w_len_raw = LW'(r_delay_length);
    always_comb begin
        if (w_len_raw == '0) begin
            w_len = LW'(1);
        end else if (w_len_raw > MAX_LEN) begin
            w_len = MAX_LEN;
        end else begin
            w_len = w_len_raw;
        end
    end
    assign w_gain = (r_gain > GAIN_UNITY) ? GAIN_UNITY : r_gain;

    // a position at or past a shortened length still serves, then wraps
    assign w_pos_inc = LW'(r_pos) + LW'(1);
    assign n_pos     = (w_pos_inc >= w_len) ? '0 : w_pos_inc[AW-1:0];

    assign w_a_move   = r_a_vld && w_free;
    assign o_in_stall = r_a_vld && !w_free;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_fill  <= '0;
            r_a_vld <= 1'b0;
        end else begin
            if (w_accept) begin
                r_pos <= n_pos;
            end
            // positions are visited upwards from zero, so writes fill a prefix
            if (w_a_move && {1'b0, r_a_addr} == r_fill) begin
                r_fill <= r_fill + (AW+1)'(1);
            end
            if (w_accept) begin
                r_a_vld <= 1'b1;
            end else if (w_a_move) begin
                r_a_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_addr    <= r_pos;
            r_a_left    <= i_left_in;
            r_a_right   <= i_right_in;
            // the word written at this edge is not yet in the read data
            r_a_fwd_vld <= w_a_move && (r_a_addr == r_pos);
            r_a_fwd     <= w_store_word;
            r_a_init    <= ({1'b0, r_pos} < r_fill);
        end
    end

    scf_ram #(
        .WIDTH (2 * SW),
        .DEPTH (MAX_DELAY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_a_move),
        .i_waddr (r_a_addr),
        .i_wdata (w_store_word),
        .i_re    (w_accept),
        .i_raddr (r_pos),
        .o_rdata (w_rdata)
    );

    always_comb begin
        if (r_a_fwd_vld) begin
            w_stored = r_a_fwd;
        end else if (r_a_init) begin
            w_stored = w_rdata;
        end else begin
            w_stored = '0;
        end
    end

    scf_lane #(
        .SAMPLE_WIDTH (SW)
    ) u_lane_left (
        .i_x    (r_a_left),
        .i_s    ($signed(w_stored[2*SW-1:SW])),
        .i_gain (w_gain),
        .o_y    (w_left_y)
    );

    scf_lane #(
        .SAMPLE_WIDTH (SW)
    ) u_lane_right (
        .i_x    (r_a_right),
        .i_s    ($signed(w_stored[SW-1:0])),
        .i_gain (w_gain),
        .o_y    (w_right_y)
    );

    scf_merge #(
        .SAMPLE_WIDTH (SW)
    ) u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_a_move),
        .i_feedback   (r_feedback),
        .i_left_x     (r_a_left),
        .i_right_x    (r_a_right),
        .i_left_y     (w_left_y),
        .i_right_y    (w_right_y),
        .o_store_word (w_store_word),
        .o_free       (w_free),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_left_out   (o_left_out),
        .o_right_out  (o_right_out)
    );

endmodule

FILE: sv/scf_checker.sv
// scf_checker: port-level assertions for stereo_comb_filter_core
// uses scf_pkg; attached to the top level by the bind at the end of this file
module scf_checker #(
    parameter int SAMPLE_WIDTH = scf_pkg::SAMPLE_WIDTH_DEF
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic signed [SAMPLE_WIDTH-1:0]    i_left_in,
    input logic signed [SAMPLE_WIDTH-1:0]    i_right_in,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic signed [SAMPLE_WIDTH-1:0]    o_left_out,
    input logic signed [SAMPLE_WIDTH-1:0]    o_right_out,
    input logic                              i_cfg_valid,
    input logic                              o_cfg_ready
);
    import scf_pkg::*;

    // a stalled result word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_left_out)
            && $stable(o_right_out))
        else $error("output word changed while stalled");

    // a held-off input word keeps its payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_left_in)
            && $stable(i_right_in))
        else $error("input word changed while stalled");

    // input is only held off when the output side is backed up
    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with output free");

    // an accepted word has a result on offer once it has passed the read stage
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |-> ##2 o_out_valid)
        else $error("no result two cycles after acceptance");

    // the user must write registers only with nothing waiting on the output; the core does not enforce it
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |-> !o_out_valid && !o_in_stall)
        else $error("register written with words in flight");

endmodule

bind stereo_comb_filter_core scf_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_scf_checker (.*);
